FILE: hdl/ptrs_pkg.sv
// shared codes, field widths and pipeline tag type for the point table search core
package ptrs_pkg;

    localparam int POS_BITS          = 16;
    localparam int LABEL_BITS        = 8;
    localparam int ENTRY_INDEX_BITS  = 10;
    localparam int RADIUS_BITS       = 16;
    localparam int RADIUS_SQ_BITS    = 2 * RADIUS_BITS;
    localparam int STATUS_BITS       = 3;
    localparam int RESULT_INDEX_BITS = 8;

    localparam logic [1:0] REQ_ADD        = 2'd0;
    localparam logic [1:0] REQ_INVALIDATE = 2'd1;
    localparam logic [1:0] REQ_MOVE       = 2'd2;
    localparam logic [1:0] REQ_SEARCH     = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd4;

    // control that travels with one entry through the distance pipeline
    typedef struct packed {
        logic vld;
        logic last;
        logic live;
    } ptrs_tag_t;

endpackage

FILE: hdl/ptrs_req_if.sv
// request channel: valid/ready handshake with the request payload
interface ptrs_req_if
    import ptrs_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [POS_BITS-1:0]         x_pos;
    logic [POS_BITS-1:0]         y_pos;
    logic [LABEL_BITS-1:0]       point_label;
    logic [ENTRY_INDEX_BITS-1:0] entry_index;
    logic [RADIUS_BITS-1:0]      radius;

    modport source (
        output valid, req_type, x_pos, y_pos, point_label, entry_index, radius,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_pos, y_pos, point_label, entry_index, radius,
        output ready
    );
endinterface

FILE: hdl/ptrs_rsp_if.sv
// result channel: valid/ready handshake with status and index
interface ptrs_rsp_if
    import ptrs_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [STATUS_BITS-1:0]       status;
    logic [RESULT_INDEX_BITS-1:0] result_index;

    modport source (
        output valid, status, result_index,
        input  ready
    );

    modport sink (
        input  valid, status, result_index,
        output ready
    );
endinterface

FILE: hdl/point_table_radius_search_core.sv
// point table with add, invalidate, move-last and radius search requests
//
//  channel   dir   handshake      beat contents
//  req       in    valid/ready    req_type, x_pos, y_pos, point_label, entry_index, radius
//  rsp       out   valid/ready    status, result_index
//
// add and the early error cases go from accept straight to the result, invalidate and move
// first read then write the entry ram, and a search scans the entries in index order
// one entry per cycle from the single ram read port and stops at the first hit.
// req.ready is high only while no request is in flight; a result beat waits in the output
// register while rsp.ready is low. reset empties the table; the ram itself is not cleared.
module point_table_radius_search_core
    import ptrs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_BITS  = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    ptrs_req_if.sink   req,
    ptrs_rsp_if.source rsp
);
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CNTW > ENTRY_INDEX_BITS) ? CNTW : ENTRY_INDEX_BITS;
    localparam int WW   = 2 * COORD_BITS + LABEL_BITS + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INV_WR = 3'd1;
    localparam logic [2:0] S_MOV_WR = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [CNTW-1:0]              count_reg, count_next;
    logic [CNTW-1:0]              scan_reg, scan_next;
    logic [IW-1:0]                addr_reg, addr_next;
    logic [COORD_BITS-1:0]        x_reg, y_reg, x_next, y_next;
    logic [RADIUS_SQ_BITS-1:0]    r2_reg;
    logic [STATUS_BITS-1:0]       res_status_reg, res_status_next;
    logic [RESULT_INDEX_BITS-1:0] res_index_reg, res_index_next;
    logic                         out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0]       out_status_reg, out_status_next;
    logic [RESULT_INDEX_BITS-1:0] out_index_reg, out_index_next;
    ptrs_tag_t                    rd_tag_reg, rd_tag_next;
    logic [IW-1:0]                rd_idx_reg;

    logic                  accept;
    logic [COORD_BITS-1:0] in_x, in_y;
    logic [IW-1:0]         last_addr;
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr, ram_raddr;
    logic [WW-1:0]         ram_wdata, ram_rdata;
    logic                  issue;
    ptrs_tag_t             dist_tag;
    logic [IW-1:0]         dist_idx;
    logic                  dist_hit;

    assign accept    = req.valid & req.ready;
    assign in_x      = COORD_BITS'(req.x_pos);
    assign in_y      = COORD_BITS'(req.y_pos);
    assign last_addr = IW'(count_reg - CNTW'(1));
    assign issue     = (state_reg == S_SEARCH) && (scan_reg < count_reg);
    assign req.ready = (state_reg == S_IDLE);

    // word layout: valid, label, y, x
    ptrs_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptrs_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_BITS   (IW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (state_reg != S_SEARCH),
        .in_tag    (rd_tag_reg),
        .in_idx    (rd_idx_reg),
        .ent_x     (ram_rdata[COORD_BITS-1:0]),
        .ent_y     (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
        .ent_valid (ram_rdata[WW-1]),
        .pt_x      (x_reg),
        .pt_y      (y_reg),
        .r2        (r2_reg),
        .out_tag   (dist_tag),
        .out_idx   (dist_idx),
        .hit       (dist_hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        addr_next       = addr_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = {1'b1, req.point_label, in_y, in_x};
        ram_raddr       = scan_reg[IW-1:0];
        rd_tag_next     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next          = in_x;
                    y_next          = in_y;
                    res_index_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            if (count_reg == CNTW'(TABLE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                ram_waddr      = count_reg[IW-1:0];
                                count_next     = count_reg + CNTW'(1);
                                res_index_next = RESULT_INDEX_BITS'(count_reg);
                            end
                        end
                        REQ_INVALIDATE:
                        begin
                            if (CMPW'(req.entry_index) >= CMPW'(count_reg))
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_raddr  = IW'(req.entry_index);
                                addr_next  = IW'(req.entry_index);
                                state_next = S_INV_WR;
                            end
                        end
                        REQ_MOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = last_addr;
                                addr_next  = last_addr;
                                state_next = S_MOV_WR;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_SEARCH;
                            end
                        end
                    endcase
                end
            end
            S_INV_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {1'b0, ram_rdata[WW-2:0]};
                state_next = S_DONE;
            end
            S_MOV_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {ram_rdata[WW-1:2*COORD_BITS], y_reg, x_reg};
                state_next = S_DONE;
            end
            S_SEARCH:
            begin
                // entries stream in index order, so the first hit is the lowest index
                rd_tag_next.vld  = issue;
                rd_tag_next.last = (scan_reg == count_reg - CNTW'(1));
                if (issue)
                begin
                    scan_next = scan_reg + CNTW'(1);
                end
                if (dist_tag.vld && dist_hit)
                begin
                    res_status_next = ST_OK;
                    res_index_next  = RESULT_INDEX_BITS'(dist_idx);
                    state_next      = S_DONE;
                end
                else if (dist_tag.vld && dist_tag.last)
                begin
                    res_status_next = ST_NOTFOUND;
                    res_index_next  = '0;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_tag_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            rd_tag_reg    <= rd_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        rd_idx_reg     <= scan_reg[IW-1:0];
        if (accept)
        begin
            r2_reg <= RADIUS_SQ_BITS'(req.radius) * RADIUS_SQ_BITS'(req.radius);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_index = out_index_reg;
endmodule

FILE: hdl/ptrs_ram.sv
// generic single write port ram with registered read
module ptrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hdl/ptrs_dist.sv
// pipelined squared distance unit, one entry per cycle, radius compare at the end
module ptrs_dist
    import ptrs_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int IDX_BITS   = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      flush,
    input  ptrs_tag_t                 in_tag,
    input  logic [IDX_BITS-1:0]       in_idx,
    input  logic [COORD_BITS-1:0]     ent_x,
    input  logic [COORD_BITS-1:0]     ent_y,
    input  logic                      ent_valid,
    input  logic [COORD_BITS-1:0]     pt_x,
    input  logic [COORD_BITS-1:0]     pt_y,
    input  logic [RADIUS_SQ_BITS-1:0] r2,
    output ptrs_tag_t                 out_tag,
    output logic [IDX_BITS-1:0]       out_idx,
    output logic                      hit
);
    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int SUM_BITS = SQ_BITS + 1;
    localparam int CMP_BITS = (SUM_BITS > RADIUS_SQ_BITS) ? SUM_BITS : RADIUS_SQ_BITS;

    ptrs_tag_t             tag1_reg, tag1_next;
    ptrs_tag_t             tag2_reg, tag2_next;
    logic [IDX_BITS-1:0]   idx1_reg, idx2_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [SQ_BITS-1:0]    sqx_reg, sqy_reg;
    logic [SUM_BITS-1:0]   dist_sum;

    always_comb
    begin
        dx_next = (ent_x >= pt_x) ? (ent_x - pt_x) : (pt_x - ent_x);
        dy_next = (ent_y >= pt_y) ? (ent_y - pt_y) : (pt_y - ent_y);

        tag1_next      = in_tag;
        tag1_next.live = in_tag.vld & ent_valid;
        tag2_next      = tag1_reg;
        if (flush)
        begin
            tag1_next.vld = 1'b0;
            tag2_next.vld = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= in_idx;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        idx2_reg <= idx1_reg;
        sqx_reg  <= SQ_BITS'(dx_reg) * SQ_BITS'(dx_reg);
        sqy_reg  <= SQ_BITS'(dy_reg) * SQ_BITS'(dy_reg);
    end

    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign out_tag  = tag2_reg;
    assign out_idx  = idx2_reg;
    assign hit      = tag2_reg.vld & tag2_reg.live &
                      (CMP_BITS'(dist_sum) < CMP_BITS'(r2));
endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the point table radius search core
module testbench
    import ptrs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH     = 256;
    localparam int COORD_W       = 16;
    localparam logic [31:0] COORD_MASK = (32'd1 << COORD_W) - 32'd1;
    localparam int PHASE_ITEMS   = 375;
    localparam int RX_HOLD_CYCLES = 700;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_REPORTS   = 40;
    localparam logic [15:0] CLUSTER_X = 16'd30000;
    localparam logic [15:0] CLUSTER_Y = 16'd12000;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [POS_BITS-1:0]         x;
        logic [POS_BITS-1:0]         y;
        logic [LABEL_BITS-1:0]       label;
        logic [ENTRY_INDEX_BITS-1:0] index;
        logic [RADIUS_BITS-1:0]      radius;
    } request_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]       status;
        logic [RESULT_INDEX_BITS-1:0] index;
    } reply_t;

    logic clk;
    logic rst_n;

    ptrs_req_if req_ch ();
    ptrs_rsp_if rsp_ch ();

    point_table_radius_search_core #(
        .TABLE_DEPTH (TBL_DEPTH),
        .COORD_BITS  (COORD_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted table contents
    logic [31:0] tbl_x [TBL_DEPTH];
    logic [31:0] tbl_y [TBL_DEPTH];
    bit          tbl_valid [TBL_DEPTH];
    int          tbl_count = 0;

    // stimulus-side view of the table, used to aim searches and invalidates
    logic [15:0] plan_x [TBL_DEPTH];
    logic [15:0] plan_y [TBL_DEPTH];
    int          plan_count = 0;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];
    request_t on_bus;

    int queued_total   = 0;
    int accepted_total = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit rx_hold        = 1'b0;
    event holdoff_ev;

    function automatic reply_t apply_request(request_t rq);
        reply_t rp;
        logic [31:0] px;
        logic [31:0] py;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned r2;
        bit hit;
        rp.status = ST_OK;
        rp.index  = '0;
        hit = 1'b0;
        px = 32'(rq.x) & COORD_MASK;
        py = 32'(rq.y) & COORD_MASK;
        case (rq.kind)
            REQ_ADD: begin
                if (tbl_count >= TBL_DEPTH) begin
                    rp.status = ST_FULL;
                end else begin
                    tbl_x[tbl_count]     = px;
                    tbl_y[tbl_count]     = py;
                    tbl_valid[tbl_count] = 1'b1;
                    rp.index = RESULT_INDEX_BITS'(tbl_count);
                    tbl_count++;
                end
            end
            REQ_INVALIDATE: begin
                if (int'(rq.index) >= tbl_count)
                    rp.status = ST_RANGE;
                else
                    tbl_valid[rq.index] = 1'b0;
            end
            REQ_MOVE: begin
                if (tbl_count == 0) begin
                    rp.status = ST_EMPTY;
                end else begin
                    tbl_x[tbl_count-1] = px;
                    tbl_y[tbl_count-1] = py;
                end
            end
            REQ_SEARCH: begin
                r2 = 64'(rq.radius);
                r2 = r2 * r2;
                for (int i = 0; i < tbl_count && !hit; i++) begin
                    dx = 64'((tbl_x[i] >= px) ? tbl_x[i] - px : px - tbl_x[i]);
                    dy = 64'((tbl_y[i] >= py) ? tbl_y[i] - py : py - tbl_y[i]);
                    if (tbl_valid[i] && dx * dx + dy * dy < r2) begin
                        rp.index = RESULT_INDEX_BITS'(i);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    rp.status = ST_NOTFOUND;
            end
        endcase
        return rp;
    endfunction

    task automatic push_request(input logic [1:0] kind, input logic [15:0] x,
                                input logic [15:0] y, input logic [7:0] label,
                                input logic [9:0] idx, input logic [15:0] radius);
        request_t rq;
        rq.kind   = kind;
        rq.x      = x;
        rq.y      = y;
        rq.label  = label;
        rq.index  = idx;
        rq.radius = radius;
        if (kind == REQ_ADD && plan_count < TBL_DEPTH) begin
            plan_x[plan_count] = x;
            plan_y[plan_count] = y;
            plan_count++;
        end else if (kind == REQ_MOVE && plan_count > 0) begin
            plan_x[plan_count-1] = x;
            plan_y[plan_count-1] = y;
        end
        pending_reqs.insert(pending_reqs.size(), rq);
        queued_total++;
    endtask

    task automatic push_random_request();
        int pick;
        int base;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] r;
        logic [9:0]  idx;
        pick = int'($urandom_range(99));
        x    = 16'($urandom);
        y    = 16'($urandom);
        r    = 16'($urandom);
        idx  = 10'($urandom);
        // half the points land in one crowded patch so several entries compete
        if ($urandom_range(1) == 1) begin
            x = 16'(CLUSTER_X + $urandom_range(255));
            y = 16'(CLUSTER_Y + $urandom_range(255));
        end
        if (pick < 30) begin
            push_request(REQ_ADD, x, y, 8'($urandom), idx, r);
        end else if (pick < 45) begin
            if (plan_count > 0 && $urandom_range(99) < 85)
                idx = 10'($urandom_range(plan_count - 1));
            push_request(REQ_INVALIDATE, x, y, 8'($urandom), idx, r);
        end else if (pick < 55) begin
            push_request(REQ_MOVE, x, y, 8'($urandom), idx, r);
        end else begin
            if (plan_count > 0 && $urandom_range(99) < 75) begin
                base = int'($urandom_range(plan_count - 1));
                x = 16'(plan_x[base] + $urandom_range(40) - 20);
                y = 16'(plan_y[base] + $urandom_range(40) - 20);
                if ($urandom_range(99) < 85)
                    r = 16'($urandom_range(64));
            end
            push_request(REQ_SEARCH, x, y, 8'($urandom), idx, r);
        end
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || expected_replies.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_replies.insert(expected_replies.size(), apply_request(on_bus));
                accepted_total++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= on_bus.kind;
                    req_ch.x_pos       <= on_bus.x;
                    req_ch.y_pos       <= on_bus.y;
                    req_ch.point_label <= on_bus.label;
                    req_ch.entry_index <= on_bus.index;
                    req_ch.radius      <= on_bus.radius;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the core backs up and stalls its input
    always begin
        @(holdoff_ev);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // reply monitor
    always @(posedge clk) begin
        reply_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: reply beat with none expected: status %0d index %0d",
                                 $time, rsp_ch.status, rsp_ch.result_index);
                end else begin
                    want = expected_replies.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, want.status, rsp_ch.status);
                    end
                    if (rsp_ch.result_index !== want.index) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: result_index expected %0d actual %0d",
                                     $time, want.index, rsp_ch.result_index);
                    end
                end
            end
            rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_ADD;
        req_ch.x_pos       = '0;
        req_ch.y_pos       = '0;
        req_ch.point_label = '0;
        req_ch.entry_index = '0;
        req_ch.radius      = '0;
        rsp_ch.ready       = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, field extremes, radius edges, invalid entries
        send_idle_pct = 28;
        recv_idle_pct = 53;
        push_request(REQ_MOVE,       16'd1234,  16'd5678,  8'd0,   10'd0,    16'd0);
        push_request(REQ_INVALIDATE, 16'd0,     16'd0,     8'd0,   10'd0,    16'd0);
        push_request(REQ_INVALIDATE, 16'hFFFF,  16'hFFFF,  8'hFF,  10'd1023, 16'hFFFF);
        push_request(REQ_SEARCH,     16'd0,     16'd0,     8'd0,   10'd0,    16'hFFFF);
        push_request(REQ_ADD,        16'd0,     16'd0,     8'd0,   10'd0,    16'd0);
        push_request(REQ_ADD,        16'hFFFF,  16'hFFFF,  8'hFF,  10'd1023, 16'hFFFF);
        push_request(REQ_SEARCH,     16'd0,     16'd0,     8'd0,   10'd0,    16'd0);
        push_request(REQ_SEARCH,     16'hFFFF,  16'hFFFF,  8'd0,   10'd0,    16'd1);
        push_request(REQ_SEARCH,     16'd0,     16'd0,     8'd0,   10'd0,    16'hFFFF);
        push_request(REQ_SEARCH,     16'd32768, 16'd32768, 8'd0,   10'd0,    16'hFFFF);
        push_request(REQ_ADD,        16'd100,   16'd100,   8'hA5,  10'd0,    16'd0);
        // squared distance equal to radius squared must miss, one more must hit
        push_request(REQ_SEARCH,     16'd103,   16'd104,   8'd0,   10'd0,    16'd5);
        push_request(REQ_SEARCH,     16'd103,   16'd104,   8'd0,   10'd0,    16'd6);
        push_request(REQ_INVALIDATE, 16'd0,     16'd0,     8'd0,   10'd0,    16'd0);
        push_request(REQ_INVALIDATE, 16'd0,     16'd0,     8'd0,   10'd0,    16'd0);
        push_request(REQ_SEARCH,     16'd0,     16'd0,     8'd0,   10'd0,    16'hFFFF);
        push_request(REQ_INVALIDATE, 16'd0,     16'd0,     8'd0,   10'd3,    16'd0);
        push_request(REQ_MOVE,       16'd200,   16'd300,   8'd0,   10'd0,    16'd0);
        push_request(REQ_SEARCH,     16'd200,   16'd300,   8'd0,   10'd0,    16'd1);
        push_request(REQ_SEARCH,     16'd100,   16'd100,   8'd0,   10'd0,    16'd2);
        push_request(REQ_INVALIDATE, 16'd0,     16'd0,     8'd0,   10'd2,    16'd0);
        push_request(REQ_MOVE,       16'd5,     16'd5,     8'd0,   10'd0,    16'd0);
        push_request(REQ_SEARCH,     16'd5,     16'd5,     8'd0,   10'd0,    16'd10);
        push_request(REQ_ADD,        16'hAAAA,  16'h5555,  8'h5A,  10'h2AA,  16'hAAAA);
        push_request(REQ_ADD,        16'h5555,  16'hAAAA,  8'hA5,  10'h155,  16'h5555);
        repeat (PHASE_ITEMS) push_random_request();
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 28;
        repeat (PHASE_ITEMS) push_random_request();
        wait_drained();

        // no idling: fill the table, overflow it, then search a full table
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (plan_count < TBL_DEPTH)
            push_request(REQ_ADD, 16'($urandom), 16'($urandom), 8'($urandom),
                         10'($urandom), 16'($urandom));
        repeat (3)
            push_request(REQ_ADD, 16'($urandom), 16'($urandom), 8'($urandom),
                         10'($urandom), 16'($urandom));
        repeat (PHASE_ITEMS) push_random_request();
        -> holdoff_ev;
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: point_table_radius_search_core.f
hdl/ptrs_pkg.sv
hdl/ptrs_req_if.sv
hdl/ptrs_rsp_if.sv
hdl/ptrs_ram.sv
hdl/ptrs_dist.sv
hdl/point_table_radius_search_core.sv
tb/sv/testbench.sv
